// ===== design/per_source_flood_detector_unit_assert.svh =====
// assertion macros shared by the flood detector modules
`ifndef PER_SOURCE_FLOOD_DETECTOR_UNIT_ASSERT_SVH
`define PER_SOURCE_FLOOD_DETECTOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define FSD_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("flood detector check failed");
`define FSD_ASSERT_ALWAYS(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("flood detector check failed");
`else
`define FSD_ASSERT_IMP(name, clk, rstn, ante, cons)
`define FSD_ASSERT_ALWAYS(name, clk, rstn, cond)
`endif

`endif

// ===== design/fsd_pkg.sv =====
package fsd_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int WINDOW_SLOTS_DEF  = 64;

    localparam logic [15:0] MIN_FRAME_LEN = 16'd34;

    localparam logic [6:0]  THRESHOLD_RST = 7'd50;
    localparam logic [7:0]  WINDOW_RST    = 8'd3;
    localparam logic [15:0] PORT_RST      = 16'd80;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_WINDOW    = 2'd1;
    localparam logic [1:0] CFG_PORT      = 2'd2;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_TCP  = 2'd1;
    localparam logic [1:0] CLASS_UDP  = 2'd2;
    localparam logic [1:0] CLASS_ICMP = 2'd3;

    localparam logic [2:0] VERDICT_IGNORED     = 3'd0;
    localparam logic [2:0] VERDICT_UNTRACKED   = 3'd1;
    localparam logic [2:0] VERDICT_BLOCKED     = 3'd2;
    localparam logic [2:0] VERDICT_COUNTED     = 3'd3;
    localparam logic [2:0] VERDICT_NEW_BLOCKED = 3'd4;

    typedef struct packed {
        logic [15:0] frame_len;
        logic [31:0] src_addr;
        logic [7:0]  ip_protocol;
        logic [15:0] dst_port;
        logic [31:0] now_seconds;
    } fsd_in_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [1:0]  traffic_class;
        logic [31:0] reported_addr;
        logic [9:0]  entry_slot;
        logic [6:0]  window_count;
        logic        evicted_flag;
    } fsd_out_t;

    typedef struct packed {
        logic [1:0]  traffic_class;
        logic [31:0] addr;
        logic [31:0] now;
    } fsd_work_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK_RD,
        ST_LOOK_CHK,
        ST_EVICT_RD,
        ST_EVICT_CHK,
        ST_WIN_RD,
        ST_WIN_CHK,
        ST_APPEND,
        ST_UPDATE,
        ST_EMIT
    } fsd_state_t;

endpackage

// ===== design/fsd_front.sv =====
module fsd_front (
    input  fsd_pkg::fsd_in_t   s_data,
    input  logic [15:0]        watched_tcp_port,
    output fsd_pkg::fsd_work_t work
);

    logic [1:0] cls;

    always_comb begin
        cls = fsd_pkg::CLASS_NONE;
        if (s_data.frame_len >= fsd_pkg::MIN_FRAME_LEN) begin
            if (s_data.ip_protocol == fsd_pkg::PROTO_TCP) begin
                if (s_data.dst_port == watched_tcp_port) begin
                    cls = fsd_pkg::CLASS_TCP;
                end
            end else if (s_data.ip_protocol == fsd_pkg::PROTO_UDP) begin
                cls = fsd_pkg::CLASS_UDP;
            end else if (s_data.ip_protocol == fsd_pkg::PROTO_ICMP) begin
                cls = fsd_pkg::CLASS_ICMP;
            end
        end
    end

    assign work.traffic_class = cls;
    assign work.addr          = s_data.src_addr;
    assign work.now           = s_data.now_seconds;

endmodule

// ===== design/fsd_queue.sv =====
`include "per_source_flood_detector_unit_assert.svh"

module fsd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  fsd_pkg::fsd_work_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fsd_pkg::fsd_work_t out_data
);

    fsd_pkg::fsd_work_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    `FSD_ASSERT_ALWAYS(a_queue_count, aclk, aresetn, count_reg <= 2'd2)

endmodule

// ===== design/fsd_engine.sv =====
`include "per_source_flood_detector_unit_assert.svh"

module fsd_engine #(
    parameter int TABLE_ENTRIES = fsd_pkg::TABLE_ENTRIES_DEF,
    parameter int WINDOW_SLOTS  = fsd_pkg::WINDOW_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               work_valid,
    output logic               work_ready,
    input  fsd_pkg::fsd_work_t work,
    input  logic [6:0]         block_threshold,
    input  logic [7:0]         window_seconds,
    output logic               m_valid,
    input  logic               m_ready,
    output fsd_pkg::fsd_out_t  m_data
);

    localparam int SLOT_W    = $clog2(TABLE_ENTRIES);
    localparam int E_W       = SLOT_W + 1;
    localparam int CNT_W     = $clog2(WINDOW_SLOTS + 1);
    localparam int IW        = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int WIN_DEPTH = TABLE_ENTRIES * (2 ** IW);

    fsd_pkg::fsd_state_t state_reg, state_next;

    logic [1:0]        cls_reg, cls_next;
    logic [31:0]       addr_reg, addr_next;
    logic [31:0]       now_reg, now_next;
    logic [E_W-1:0]    ek_reg, ek_next;
    logic [CNT_W-1:0]  wk_reg, wk_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              blocked_reg, blocked_next;
    logic              ev_reg, ev_next;
    logic              any_reg, any_next;
    logic [31:0]       oldest_reg, oldest_next;
    logic [2:0]        verdict_reg, verdict_next;
    logic [E_W-1:0]    inuse_reg, inuse_next;
    logic              out_valid_reg, out_valid_next;
    fsd_pkg::fsd_out_t out_data_reg, out_data_next;

    // entry table
    logic [31:0]       ent_addr_mem [TABLE_ENTRIES];
    logic              ent_blk_mem  [TABLE_ENTRIES];
    logic [CNT_W-1:0]  ent_cnt_mem  [TABLE_ENTRIES];
    logic [31:0]       ent_seen_mem [TABLE_ENTRIES];
    logic [31:0]       ent_addr_rd_reg;
    logic              ent_blk_rd_reg;
    logic [CNT_W-1:0]  ent_cnt_rd_reg;
    logic [31:0]       ent_seen_rd_reg;
    logic              ent_we;

    // window times, one row per entry
    logic [31:0]          win_mem [WIN_DEPTH];
    logic [31:0]          win_rd_reg;
    logic                 win_we;
    logic [SLOT_W+IW-1:0] win_waddr;
    logic [31:0]          win_wdata;
    logic [SLOT_W+IW-1:0] win_raddr;

    logic             start, look_hit, look_last, table_full, evict_better, evict_last;
    logic             any_after, win_last, win_keep, kept_lt, out_free;
    logic [CNT_W-1:0] thr, kept_after;

    assign start        = work_valid && (state_reg == fsd_pkg::ST_IDLE);
    assign work_ready   = (state_reg == fsd_pkg::ST_IDLE);
    assign look_hit     = (ent_addr_rd_reg == addr_reg);
    assign look_last    = (E_W'(ek_reg + E_W'(1)) == inuse_reg);
    assign table_full   = (inuse_reg == E_W'(TABLE_ENTRIES));
    assign evict_better = !ent_blk_rd_reg && (ent_seen_rd_reg < oldest_reg);
    assign evict_last   = (ek_reg == E_W'(TABLE_ENTRIES - 1));
    assign any_after    = any_reg || evict_better;
    assign win_last     = (CNT_W'(wk_reg + CNT_W'(1)) == cnt_reg);
    assign win_keep     = (win_rd_reg > now_reg) ||
                          ((now_reg - win_rd_reg) < 32'(window_seconds));
    assign thr          = (int'(block_threshold) > WINDOW_SLOTS) ?
                          CNT_W'(WINDOW_SLOTS) : CNT_W'(block_threshold);
    assign kept_lt      = (kept_reg < thr);
    assign kept_after   = kept_lt ? CNT_W'(kept_reg + CNT_W'(1)) : kept_reg;
    assign out_free     = !out_valid_reg || m_ready;
    assign win_raddr    = {slot_reg, wk_reg[IW-1:0]};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fsd_pkg::ST_IDLE: begin
                if (work_valid) begin
                    if (work.traffic_class == fsd_pkg::CLASS_NONE) begin
                        state_next = fsd_pkg::ST_EMIT;
                    end else if (inuse_reg == '0) begin
                        state_next = fsd_pkg::ST_APPEND;
                    end else begin
                        state_next = fsd_pkg::ST_LOOK_RD;
                    end
                end
            end
            fsd_pkg::ST_LOOK_RD: state_next = fsd_pkg::ST_LOOK_CHK;
            fsd_pkg::ST_LOOK_CHK: begin
                if (look_hit) begin
                    if (ent_blk_rd_reg) begin
                        state_next = fsd_pkg::ST_UPDATE;
                    end else if (ent_cnt_rd_reg == '0) begin
                        state_next = fsd_pkg::ST_APPEND;
                    end else begin
                        state_next = fsd_pkg::ST_WIN_RD;
                    end
                end else if (look_last) begin
                    state_next = table_full ? fsd_pkg::ST_EVICT_RD : fsd_pkg::ST_APPEND;
                end else begin
                    state_next = fsd_pkg::ST_LOOK_RD;
                end
            end
            fsd_pkg::ST_EVICT_RD: state_next = fsd_pkg::ST_EVICT_CHK;
            fsd_pkg::ST_EVICT_CHK: begin
                if (evict_last) begin
                    state_next = any_after ? fsd_pkg::ST_APPEND : fsd_pkg::ST_EMIT;
                end else begin
                    state_next = fsd_pkg::ST_EVICT_RD;
                end
            end
            fsd_pkg::ST_WIN_RD: state_next = fsd_pkg::ST_WIN_CHK;
            fsd_pkg::ST_WIN_CHK: begin
                state_next = win_last ? fsd_pkg::ST_APPEND : fsd_pkg::ST_WIN_RD;
            end
            fsd_pkg::ST_APPEND: state_next = fsd_pkg::ST_UPDATE;
            fsd_pkg::ST_UPDATE: state_next = fsd_pkg::ST_EMIT;
            fsd_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = fsd_pkg::ST_IDLE;
                end
            end
            default: state_next = fsd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cls_next       = cls_reg;
        addr_next      = addr_reg;
        now_next       = now_reg;
        ek_next        = ek_reg;
        wk_next        = wk_reg;
        kept_next      = kept_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        blocked_next   = blocked_reg;
        ev_next        = ev_reg;
        any_next       = any_reg;
        oldest_next    = oldest_reg;
        verdict_next   = verdict_reg;
        inuse_next     = inuse_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        ent_we         = 1'b0;
        win_we         = 1'b0;
        win_waddr      = {slot_reg, kept_reg[IW-1:0]};
        win_wdata      = now_reg;
        case (state_reg)
            fsd_pkg::ST_IDLE: begin
                if (start) begin
                    cls_next     = work.traffic_class;
                    addr_next    = work.addr;
                    now_next     = work.now;
                    ek_next      = '0;
                    wk_next      = '0;
                    kept_next    = '0;
                    cnt_next     = '0;
                    slot_next    = '0;
                    blocked_next = 1'b0;
                    ev_next      = 1'b0;
                    any_next     = 1'b0;
                    oldest_next  = work.now;
                    verdict_next = fsd_pkg::VERDICT_IGNORED;
                    if (work.traffic_class != fsd_pkg::CLASS_NONE && inuse_reg == '0) begin
                        inuse_next = E_W'(1);
                    end
                end
            end
            fsd_pkg::ST_LOOK_CHK: begin
                if (look_hit) begin
                    slot_next    = ek_reg[SLOT_W-1:0];
                    blocked_next = ent_blk_rd_reg;
                    cnt_next     = ent_cnt_rd_reg;
                    if (ent_blk_rd_reg) begin
                        verdict_next = fsd_pkg::VERDICT_BLOCKED;
                    end
                end else if (look_last) begin
                    if (table_full) begin
                        ek_next = '0;
                    end else begin
                        slot_next  = inuse_reg[SLOT_W-1:0];
                        inuse_next = E_W'(inuse_reg + E_W'(1));
                    end
                end else begin
                    ek_next = E_W'(ek_reg + E_W'(1));
                end
            end
            fsd_pkg::ST_EVICT_CHK: begin
                if (evict_better) begin
                    oldest_next = ent_seen_rd_reg;
                    slot_next   = ek_reg[SLOT_W-1:0];
                    any_next    = 1'b1;
                end
                if (evict_last) begin
                    if (!any_after) begin
                        verdict_next = fsd_pkg::VERDICT_UNTRACKED;
                        slot_next    = '0;
                    end else begin
                        ev_next = 1'b1;
                    end
                end else begin
                    ek_next = E_W'(ek_reg + E_W'(1));
                end
            end
            fsd_pkg::ST_WIN_CHK: begin
                if (win_keep) begin
                    win_we    = 1'b1;
                    win_wdata = win_rd_reg;
                    kept_next = CNT_W'(kept_reg + CNT_W'(1));
                end
                wk_next = CNT_W'(wk_reg + CNT_W'(1));
            end
            fsd_pkg::ST_APPEND: begin
                win_we       = kept_lt;
                cnt_next     = kept_after;
                blocked_next = (kept_after >= thr);
                verdict_next = (kept_after >= thr) ? fsd_pkg::VERDICT_NEW_BLOCKED :
                                                     fsd_pkg::VERDICT_COUNTED;
            end
            fsd_pkg::ST_UPDATE: begin
                ent_we = 1'b1;
            end
            fsd_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next              = 1'b1;
                    out_data_next.verdict       = verdict_reg;
                    out_data_next.traffic_class = cls_reg;
                    out_data_next.reported_addr =
                        (verdict_reg == fsd_pkg::VERDICT_IGNORED) ? 32'd0 : addr_reg;
                    out_data_next.entry_slot    = 10'(slot_reg);
                    out_data_next.window_count  = 7'(cnt_reg);
                    out_data_next.evicted_flag  = ev_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fsd_pkg::ST_IDLE;
            inuse_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            inuse_reg     <= inuse_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cls_reg      <= cls_next;
        addr_reg     <= addr_next;
        now_reg      <= now_next;
        ek_reg       <= ek_next;
        wk_reg       <= wk_next;
        kept_reg     <= kept_next;
        cnt_reg      <= cnt_next;
        slot_reg     <= slot_next;
        blocked_reg  <= blocked_next;
        ev_reg       <= ev_next;
        any_reg      <= any_next;
        oldest_reg   <= oldest_next;
        verdict_reg  <= verdict_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_addr_mem[slot_reg] <= addr_reg;
            ent_blk_mem[slot_reg]  <= blocked_reg;
            ent_cnt_mem[slot_reg]  <= cnt_reg;
            ent_seen_mem[slot_reg] <= now_reg;
        end
        ent_addr_rd_reg <= ent_addr_mem[ek_reg[SLOT_W-1:0]];
        ent_blk_rd_reg  <= ent_blk_mem[ek_reg[SLOT_W-1:0]];
        ent_cnt_rd_reg  <= ent_cnt_mem[ek_reg[SLOT_W-1:0]];
        ent_seen_rd_reg <= ent_seen_mem[ek_reg[SLOT_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (win_we) begin
            win_mem[win_waddr] <= win_wdata;
        end
        win_rd_reg <= win_mem[win_raddr];
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `FSD_ASSERT_ALWAYS(a_inuse_bound, aclk, aresetn, inuse_reg <= E_W'(TABLE_ENTRIES))
    `FSD_ASSERT_IMP(a_evict_needs_full, aclk, aresetn, out_valid_reg && out_data_reg.evicted_flag, table_full)
    `FSD_ASSERT_IMP(a_ignored_clean, aclk, aresetn, out_valid_reg && out_data_reg.verdict == fsd_pkg::VERDICT_IGNORED, out_data_reg.entry_slot == 10'd0 && out_data_reg.window_count == 7'd0)

endmodule

// ===== design/per_source_flood_detector_unit.sv =====
// Per-source flood detector. Each s_ word is one parsed IPv4 header; each
// m_ word is its verdict, in input order. A two-word queue after the
// classifier keeps taking input while the table engine works, until it
// is full. Ignored frames go straight to the output. A monitored packet
// searches the table entries in use until it finds the source, scans all
// TABLE_ENTRIES for an eviction when the table is full and the source is
// new, and reads each window time held for the source. The entry table and
// the window memory each have a single read port. The stores need no
// clearing pass after reset.
module per_source_flood_detector_unit #(
    parameter int TABLE_ENTRIES = fsd_pkg::TABLE_ENTRIES_DEF,
    parameter int WINDOW_SLOTS  = fsd_pkg::WINDOW_SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [15:0]       cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  fsd_pkg::fsd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fsd_pkg::fsd_out_t m_data
);

    logic [6:0]  threshold_reg, threshold_next;
    logic [7:0]  window_reg, window_next;
    logic [15:0] port_reg, port_next;

    fsd_pkg::fsd_work_t front_work, queue_work;
    logic               queue_valid, queue_ready;

    always_comb begin
        threshold_next = threshold_reg;
        window_next    = window_reg;
        port_next      = port_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                fsd_pkg::CFG_THRESHOLD: threshold_next = cfg_wdata[6:0];
                fsd_pkg::CFG_WINDOW:    window_next    = cfg_wdata[7:0];
                fsd_pkg::CFG_PORT:      port_next      = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= fsd_pkg::THRESHOLD_RST;
            window_reg    <= fsd_pkg::WINDOW_RST;
            port_reg      <= fsd_pkg::PORT_RST;
        end else begin
            threshold_reg <= threshold_next;
            window_reg    <= window_next;
            port_reg      <= port_next;
        end
    end

    fsd_front u_front (
        .s_data           (s_data),
        .watched_tcp_port (port_reg),
        .work             (front_work)
    );

    fsd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (front_work),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_data  (queue_work)
    );

    fsd_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .WINDOW_SLOTS  (WINDOW_SLOTS)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .work_valid      (queue_valid),
        .work_ready      (queue_ready),
        .work            (queue_work),
        .block_threshold (threshold_reg),
        .window_seconds  (window_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule
